// ----- design/jpws_pkg.sv -----
// Shared types, constants and helpers of the joystick packet to wheel speed block.
`default_nettype none

package jpws_pkg;

    // Default limit on content bytes per packet.
    localparam int MAX_PACKET_BYTES_DEF = 127;

    // Field widths.
    localparam int BYTE_W  = 8;
    localparam int DZ_W    = 7;
    localparam int GAIN_W  = 4;
    localparam int SPEED_W = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 2'd3;

    // Register reset values.
    localparam logic [DZ_W-1:0]    DEAD_ZONE_RST   = 7'd5;
    localparam logic [GAIN_W-1:0]  BASE_GAIN_RST   = 4'd4;
    localparam logic [GAIN_W-1:0]  TURN_GAIN_RST   = 4'd2;
    localparam logic [SPEED_W-1:0] SPEED_LIMIT_RST = 12'd400;

    // Characters of the packet syntax.
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;  // '['
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;  // ']'
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    // Length of the packet tag.
    localparam logic [3:0] TAG_LEN = 4'd8;

    // Characters of the tag "joystick".
    function automatic logic [BYTE_W-1:0] tag_char(input logic [2:0] pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            3'd0:    c = 8'h6A;  // j
            3'd1:    c = 8'h6F;  // o
            3'd2:    c = 8'h79;  // y
            3'd3:    c = 8'h73;  // s
            3'd4:    c = 8'h74;  // t
            3'd5:    c = 8'h69;  // i
            3'd6:    c = 8'h63;  // c
            3'd7:    c = 8'h6B;  // k
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // What the parser hands to the mixing stage for one byte.
    typedef struct packed {
        logic              fire;     // a complete joystick packet closed on this byte
        logic [BYTE_W-1:0] forward;  // forward stick value, two's complement
        logic [BYTE_W-1:0] turn;     // turn stick value, two's complement
    } parse_out_t;

endpackage

`default_nettype wire

// ----- design/jpws_parser.sv -----
// Byte-level packet framer, tokenizer and value parser.
`default_nettype none

module jpws_parser #(
    parameter int MAX_PACKET_BYTES = jpws_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [jpws_pkg::BYTE_W-1:0] rx_byte,
    output jpws_pkg::parse_out_t             result
);

    localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 2);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PACKET_BYTES);

    typedef enum logic [2:0] {
        PH_SKIP    = 3'b001,
        PH_DIGITS  = 3'b010,
        PH_STOPPED = 3'b100
    } phase_t;

    logic                        in_packet_reg, in_packet_next;
    logic                        content_ended_reg, content_ended_next;
    logic [CNT_W-1:0]            byte_count_reg, byte_count_next;
    logic [2:0]                  token_index_reg, token_index_next;
    logic                        inside_token_reg, inside_token_next;
    logic [3:0]                  tag_position_reg, tag_position_next;
    logic                        tag_matches_reg, tag_matches_next;
    phase_t                      phase_reg, phase_next;
    logic                        negative_sign_reg, negative_sign_next;
    logic [jpws_pkg::BYTE_W-1:0] accumulator_reg, accumulator_next;
    logic [jpws_pkg::BYTE_W-1:0] forward_value_reg, forward_value_next;
    logic [jpws_pkg::BYTE_W-1:0] turn_value_reg, turn_value_next;

    // Value of the token that is open, and the stick values after it closes.
    logic [jpws_pkg::BYTE_W-1:0] token_value;
    logic [jpws_pkg::BYTE_W-1:0] fin_forward, fin_turn;
    logic                        is_digit, is_space, is_sign;
    logic [2:0]                  ti_eff;
    phase_t                      ph_eff;
    logic                        neg_eff;
    logic [jpws_pkg::BYTE_W-1:0] acc_eff;
    logic [jpws_pkg::BYTE_W-1:0] acc_times_ten;

    always_comb
    begin
        token_value = negative_sign_reg ? 8'(8'd0 - accumulator_reg) : accumulator_reg;
        fin_forward = forward_value_reg;
        fin_turn    = turn_value_reg;
        if (inside_token_reg && token_index_reg == 3'd3)
        begin
            fin_forward = token_value;
        end
        if (inside_token_reg && token_index_reg == 3'd5)
        begin
            fin_turn = token_value;
        end
    end

    always_comb
    begin
        is_digit = rx_byte inside {[jpws_pkg::CH_ZERO:jpws_pkg::CH_NINE]};
        is_space = rx_byte inside {[jpws_pkg::CH_TAB:jpws_pkg::CH_CR], jpws_pkg::CH_SPACE};
        is_sign  = rx_byte inside {jpws_pkg::CH_MINUS, jpws_pkg::CH_PLUS};

        // A byte that opens a token resets the number parser first.
        if (!inside_token_reg)
        begin
            ti_eff  = (token_index_reg != 3'd7) ? token_index_reg + 3'd1 : token_index_reg;
            ph_eff  = PH_SKIP;
            neg_eff = 1'b0;
            acc_eff = '0;
        end
        else
        begin
            ti_eff  = token_index_reg;
            ph_eff  = phase_reg;
            neg_eff = negative_sign_reg;
            acc_eff = accumulator_reg;
        end
        acc_times_ten = 8'({acc_eff, 3'b000}) + 8'({acc_eff, 1'b0})
                        + 8'(rx_byte - jpws_pkg::CH_ZERO);
    end

    always_comb
    begin
        in_packet_next     = in_packet_reg;
        content_ended_next = content_ended_reg;
        byte_count_next    = byte_count_reg;
        token_index_next   = token_index_reg;
        inside_token_next  = inside_token_reg;
        tag_position_next  = tag_position_reg;
        tag_matches_next   = tag_matches_reg;
        phase_next         = phase_reg;
        negative_sign_next = negative_sign_reg;
        accumulator_next   = accumulator_reg;
        forward_value_next = forward_value_reg;
        turn_value_next    = turn_value_reg;

        result.fire    = 1'b0;
        result.forward = fin_forward;
        result.turn    = fin_turn;

        if (accept)
        begin
            if (!in_packet_reg)
            begin
                if (rx_byte == jpws_pkg::CH_OPEN)
                begin
                    in_packet_next     = 1'b1;
                    content_ended_next = 1'b0;
                    byte_count_next    = '0;
                    token_index_next   = '0;
                    inside_token_next  = 1'b0;
                    tag_position_next  = '0;
                    tag_matches_next   = 1'b1;
                    phase_next         = PH_SKIP;
                    negative_sign_next = 1'b0;
                    accumulator_next   = '0;
                end
            end
            else if (rx_byte == jpws_pkg::CH_CLOSE)
            begin
                in_packet_next = 1'b0;
                if (!content_ended_reg)
                begin
                    forward_value_next = fin_forward;
                    turn_value_next    = fin_turn;
                    inside_token_next  = 1'b0;
                end
                result.fire = (byte_count_reg <= CNT_MAX) && tag_matches_reg
                              && (tag_position_reg == jpws_pkg::TAG_LEN)
                              && (token_index_reg >= 3'd5);
            end
            else
            begin
                if (byte_count_reg <= CNT_MAX)
                begin
                    byte_count_next = byte_count_reg + CNT_W'(1);
                end
                if (!content_ended_reg)
                begin
                    if (rx_byte == jpws_pkg::CH_NUL || rx_byte == jpws_pkg::CH_COMMA)
                    begin
                        forward_value_next = fin_forward;
                        turn_value_next    = fin_turn;
                        inside_token_next  = 1'b0;
                        if (rx_byte == jpws_pkg::CH_NUL)
                        begin
                            content_ended_next = 1'b1;
                        end
                    end
                    else
                    begin
                        inside_token_next  = 1'b1;
                        token_index_next   = ti_eff;
                        phase_next         = ph_eff;
                        negative_sign_next = neg_eff;
                        accumulator_next   = acc_eff;
                        if (ti_eff == 3'd1)
                        begin
                            // The first token is compared against the tag.
                            if (!(tag_position_reg < jpws_pkg::TAG_LEN
                                  && rx_byte == jpws_pkg::tag_char(tag_position_reg[2:0])))
                            begin
                                tag_matches_next = 1'b0;
                            end
                            if (tag_position_reg != 4'd15)
                            begin
                                tag_position_next = tag_position_reg + 4'd1;
                            end
                        end
                        else
                        begin
                            case (ph_eff)
                                PH_SKIP:
                                begin
                                    if (is_sign)
                                    begin
                                        negative_sign_next = (rx_byte == jpws_pkg::CH_MINUS);
                                        phase_next         = PH_DIGITS;
                                    end
                                    else if (is_digit)
                                    begin
                                        accumulator_next = acc_times_ten;
                                        phase_next       = PH_DIGITS;
                                    end
                                    else if (!is_space)
                                    begin
                                        phase_next = PH_STOPPED;
                                    end
                                end
                                PH_DIGITS:
                                begin
                                    if (is_digit)
                                    begin
                                        accumulator_next = acc_times_ten;
                                    end
                                    else
                                    begin
                                        phase_next = PH_STOPPED;
                                    end
                                end
                                default:
                                begin
                                    phase_next = PH_STOPPED;
                                end
                            endcase
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg     <= 1'b0;
            content_ended_reg <= 1'b0;
            byte_count_reg    <= '0;
            token_index_reg   <= '0;
            inside_token_reg  <= 1'b0;
            tag_position_reg  <= '0;
            tag_matches_reg   <= 1'b1;
            phase_reg         <= PH_SKIP;
            negative_sign_reg <= 1'b0;
            accumulator_reg   <= '0;
            forward_value_reg <= '0;
            turn_value_reg    <= '0;
        end
        else
        begin
            in_packet_reg     <= in_packet_next;
            content_ended_reg <= content_ended_next;
            byte_count_reg    <= byte_count_next;
            token_index_reg   <= token_index_next;
            inside_token_reg  <= inside_token_next;
            tag_position_reg  <= tag_position_next;
            tag_matches_reg   <= tag_matches_next;
            phase_reg         <= phase_next;
            negative_sign_reg <= negative_sign_next;
            accumulator_reg   <= accumulator_next;
            forward_value_reg <= forward_value_next;
            turn_value_reg    <= turn_value_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/jpws_mixer.sv -----
// Dead zone, gain and clamp logic that turns stick values into wheel speeds.
`default_nettype none

module jpws_mixer (
    input  wire logic [jpws_pkg::BYTE_W-1:0]  forward,
    input  wire logic [jpws_pkg::BYTE_W-1:0]  turn,
    input  wire logic [jpws_pkg::DZ_W-1:0]    dead_zone,
    input  wire logic [jpws_pkg::GAIN_W-1:0]  base_gain,
    input  wire logic [jpws_pkg::GAIN_W-1:0]  turn_gain,
    input  wire logic [jpws_pkg::SPEED_W-1:0] speed_limit,
    output logic      [jpws_pkg::SPEED_W-1:0] left_speed,
    output logic      [jpws_pkg::SPEED_W-1:0] right_speed
);

    logic [7:0]         fw_mag, tr_mag, fw_z, tr_z;
    logic [10:0]        base;
    logic signed [12:0] diff;
    logic signed [13:0] base_s, diff_s, left_s, right_s;

    always_comb
    begin
        // Magnitudes fit in eight unsigned bits, including that of -128.
        fw_mag = forward[7] ? 8'(8'd0 - forward) : forward;
        tr_mag = turn[7] ? 8'(8'd0 - turn) : turn;
        fw_z   = (fw_mag < {1'b0, dead_zone}) ? 8'd0 : fw_mag;
        tr_z   = (tr_mag < {1'b0, dead_zone}) ? 8'd0 : turn;

        base = {3'd0, fw_z} * {7'd0, base_gain};
        if (base != 11'd0)
        begin
            diff = $signed({{5{tr_z[7]}}, tr_z}) * $signed({9'd0, turn_gain});
        end
        else
        begin
            diff = '0;
        end

        base_s  = $signed({3'd0, base});
        diff_s  = $signed({diff[12], diff});
        left_s  = base_s + diff_s;
        right_s = base_s - diff_s;

        if (left_s[13])
        begin
            left_speed = '0;
        end
        else if (left_s[12:0] > {1'b0, speed_limit})
        begin
            left_speed = speed_limit;
        end
        else
        begin
            left_speed = left_s[11:0];
        end

        if (right_s[13])
        begin
            right_speed = '0;
        end
        else if (right_s[12:0] > {1'b0, speed_limit})
        begin
            right_speed = speed_limit;
        end
        else
        begin
            right_speed = right_s[11:0];
        end
    end

endmodule

`default_nettype wire

// ----- design/joystick_packet_to_wheel_speeds_core.sv -----
// Top level: joystick packet decoder with differential wheel speed output.
// The closing ']' loads the mixing stage register; the output register then raises m_tvalid.
// Throughput: one received byte per cycle while s_tready is high; the parser updates its state on every transfer.
// A mixing stage register and an output register separate the two sides, so input keeps
// flowing while one finished result waits for m_tready; a second one stalls s_tready.
// Reset (rst_n, asynchronous, active low) clears the parser and loads the register defaults.
`default_nettype none

module joystick_packet_to_wheel_speeds_core #(
    parameter int MAX_PACKET_BYTES = jpws_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Received byte stream.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] rx_byte
    // Wheel speed results.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [23:0]                          m_tdata,   // [11:0] left_speed,
                                                            // [23:12] right_speed
    // Configuration write port.
    input  wire logic                            cfg_we,
    input  wire logic [jpws_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [jpws_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [jpws_pkg::DZ_W-1:0]    dead_zone_reg;
    logic [jpws_pkg::GAIN_W-1:0]  base_gain_reg;
    logic [jpws_pkg::GAIN_W-1:0]  turn_gain_reg;
    logic [jpws_pkg::SPEED_W-1:0] speed_limit_reg;

    // Stage between the parser and the mixer holds the stick values of a closed packet.
    logic                         mix_valid_reg;
    logic [jpws_pkg::BYTE_W-1:0]  mix_forward_reg;
    logic [jpws_pkg::BYTE_W-1:0]  mix_turn_reg;

    logic                         out_valid_reg;
    logic [23:0]                  out_data_reg;

    logic                         in_xfer;
    logic                         out_free;
    logic                         mix_free;
    jpws_pkg::parse_out_t         parsed;
    logic [jpws_pkg::SPEED_W-1:0] left_speed, right_speed;

    // The output register frees up when it is empty or its transfer completes this cycle;
    // the mixing stage frees up when it is empty or drains into the output register.
    assign out_free = !out_valid_reg || m_tready;
    assign mix_free = !mix_valid_reg || out_free;
    assign s_tready = mix_free;
    assign in_xfer  = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    jpws_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_xfer),
        .rx_byte (s_tdata),
        .result  (parsed)
    );

    jpws_mixer u_mixer (
        .forward     (mix_forward_reg),
        .turn        (mix_turn_reg),
        .dead_zone   (dead_zone_reg),
        .base_gain   (base_gain_reg),
        .turn_gain   (turn_gain_reg),
        .speed_limit (speed_limit_reg),
        .left_speed  (left_speed),
        .right_speed (right_speed)
    );

    // Configuration registers; the user must write them only while idle; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg   <= jpws_pkg::DEAD_ZONE_RST;
            base_gain_reg   <= jpws_pkg::BASE_GAIN_RST;
            turn_gain_reg   <= jpws_pkg::TURN_GAIN_RST;
            speed_limit_reg <= jpws_pkg::SPEED_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                jpws_pkg::CFG_DEAD_ZONE:   dead_zone_reg   <= cfg_data[jpws_pkg::DZ_W-1:0];
                jpws_pkg::CFG_BASE_GAIN:   base_gain_reg   <= cfg_data[jpws_pkg::GAIN_W-1:0];
                jpws_pkg::CFG_TURN_GAIN:   turn_gain_reg   <= cfg_data[jpws_pkg::GAIN_W-1:0];
                jpws_pkg::CFG_SPEED_LIMIT: speed_limit_reg <= cfg_data[jpws_pkg::SPEED_W-1:0];
                default:                   speed_limit_reg <= speed_limit_reg;
            endcase
        end
    end

    // Valid flags of the two result stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mix_free)
            begin
                mix_valid_reg <= parsed.fire;
            end
            if (out_free)
            begin
                out_valid_reg <= mix_valid_reg;
            end
        end
    end

    // Payload registers need no reset; they load only when their stage moves.
    always_ff @(posedge clk)
    begin
        if (mix_free && parsed.fire)
        begin
            mix_forward_reg <= parsed.forward;
            mix_turn_reg    <= parsed.turn;
        end
        if (out_free && mix_valid_reg)
        begin
            out_data_reg <= {right_speed, left_speed};
        end
    end

endmodule

`default_nettype wire
